[rtl/broadcast_offset_mapper_assert.svh]
// ----------------------------------------------------------------------------
// broadcast_offset_mapper_assert.svh
// Assertion macros used by the checker of the offset mapper.
// ----------------------------------------------------------------------------
`ifndef BROADCAST_OFFSET_MAPPER_ASSERT_SVH
`define BROADCAST_OFFSET_MAPPER_ASSERT_SVH

// Checked on every edge outside reset.
`define BOM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define BOM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/bom_pkg.sv]
// ----------------------------------------------------------------------------
// bom_pkg
// Types and constants of the broadcast offset mapper.
// ----------------------------------------------------------------------------
package bom_pkg;

   localparam int SLOT_BITS     = 16;
   localparam int NUM_SLOTS     = 8;
   localparam int RANK_BITS     = 4;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 64;
   localparam int IN_BITS       = 32;
   localparam int OUT_BITS      = 32;
   // quotient bits resolved per divider stage
   localparam int STEP_BITS     = 4;

   localparam logic [RANK_BITS-1:0]     RANK_RESET = 4'd1;
   localparam logic [CSR_DATA_BITS-1:0] DIMS_RESET = 64'h0001_0001_0001_0001;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_RANK    = 3'd0,
      CSR_OUT_LO  = 3'd1,
      CSR_OUT_HI  = 3'd2,
      CSR_SRC_LO  = 3'd3,
      CSR_SRC_HI  = 3'd4
   } csr_index_type;

endpackage

[rtl/bom_if.sv]
// ----------------------------------------------------------------------------
// bom_if
// Channel interfaces of the broadcast offset mapper.
// ----------------------------------------------------------------------------
interface bom_req_if import bom_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [IN_BITS-1:0]  out_offset;
   modport source (output valid, output out_offset, input ready);
   modport sink   (input valid, input out_offset, output ready);
endinterface

interface bom_rsp_if import bom_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OUT_BITS-1:0] src_offset;
   logic                bad_dims;
   modport source (output valid, output src_offset, output bad_dims, input ready);
   modport sink   (input valid, input src_offset, input bad_dims, output ready);
endinterface

interface bom_csr_if import bom_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/broadcast_offset_mapper.sv]
// ----------------------------------------------------------------------------
// broadcast_offset_mapper
// Maps a flat offset in a broadcast output tensor to the source offset.
// ----------------------------------------------------------------------------
// One item per cycle while the output is not stalled. Each dimension is
// peeled off by a pipelined restoring divider that resolves four quotient
// bits per stage, then one multiply-add stage per dimension rebuilds the
// source offset. A result left waiting at the output stalls the whole
// pipeline. Unused outer dimensions are treated as size 1. Configuration
// is taken at any time but must only change while the pipeline is empty.
// ----------------------------------------------------------------------------
module broadcast_offset_mapper import bom_pkg::*; #(
   parameter int MAX_RANK    = 8,
   parameter int DIM_BITS    = 16,
   parameter int OFFSET_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   bom_req_if.sink    req,
   bom_rsp_if.source  rsp,
   bom_csr_if.sink    csr
);

   localparam int SPD = (OFFSET_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int QW  = SPD * STEP_BITS;
   localparam int ND  = MAX_RANK * SPD;
   localparam int NS  = ND + MAX_RANK;
   localparam int RW  = $clog2(MAX_RANK + 1);

   // configuration registers
   logic [RANK_BITS-1:0]     rank_ff;
   logic [CSR_DATA_BITS-1:0] out_lo_ff, out_hi_ff, src_lo_ff, src_hi_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff   <= RANK_RESET;
         out_lo_ff <= DIMS_RESET;
         out_hi_ff <= DIMS_RESET;
         src_lo_ff <= DIMS_RESET;
         src_hi_ff <= DIMS_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_RANK:   rank_ff   <= csr.data[RANK_BITS-1:0];
            CSR_OUT_LO: out_lo_ff <= csr.data;
            CSR_OUT_HI: out_hi_ff <= csr.data;
            CSR_SRC_LO: src_lo_ff <= csr.data;
            CSR_SRC_HI: src_hi_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // active rank, clamped
   logic [RW-1:0] act_rank;
   logic [RW-1:0] pad;

   always_comb begin
      if (rank_ff == '0)
         act_rank = RW'(1);
      else if (rank_ff > RANK_BITS'(MAX_RANK))
         act_rank = RW'(MAX_RANK);
      else
         act_rank = rank_ff[RW-1:0];
      pad = RW'(MAX_RANK) - act_rank;
   end

   // dimensions right-aligned to the innermost slot, outer slots padded to 1
   logic [2*CSR_DATA_BITS-1:0]          out_all, src_all;
   logic [MAX_RANK-1:0][DIM_BITS-1:0]   od_eff, sd_eff;
   logic                                bad;

   assign out_all = {out_hi_ff, out_lo_ff};
   assign src_all = {src_hi_ff, src_lo_ff};

   always_comb begin
      bad = 1'b0;
      for (int j = 0; j < MAX_RANK; j++) begin
         od_eff[j] = DIM_BITS'(1);
         sd_eff[j] = DIM_BITS'(1);
         for (int k = 0; k < MAX_RANK; k++) begin
            if (int'(pad) + k == j) begin
               od_eff[j] = out_all[k*SLOT_BITS +: DIM_BITS];
               sd_eff[j] = src_all[k*SLOT_BITS +: DIM_BITS];
            end
         end
         if (od_eff[j] == '0)
            bad = 1'b1;
      end
   end

   // pipeline registers
   logic                              v_ff   [NS];
   logic [QW-1:0]                     q_ff   [ND];
   logic [DIM_BITS-1:0]               r_ff   [ND];
   logic [MAX_RANK-1:0][DIM_BITS-1:0] c_ff   [NS];
   logic [OFFSET_BITS-1:0]            acc_ff [MAX_RANK];
   logic                              advance;

   // global stall from the output stage
   assign advance   = !v_ff[NS-1] || rsp.ready;
   assign req.ready = advance;

   // divider stages: innermost dimension first
   for (genvar s = 0; s < ND; s++) begin : g_div
      localparam int J    = MAX_RANK - 1 - s / SPD;
      localparam int STEP = s % SPD;

      logic                              v_prev;
      logic [QW-1:0]                     q_prev, q_in;
      logic [DIM_BITS-1:0]               r_prev, r_in;
      logic [MAX_RANK-1:0][DIM_BITS-1:0] c_prev, c_in;

      if (s == 0) begin : g_first
         assign v_prev = req.valid;
         assign q_prev = QW'(OFFSET_BITS'(req.out_offset));
         assign c_prev = '0;
      end else begin : g_next
         assign v_prev = v_ff[s-1];
         assign q_prev = q_ff[s-1];
         assign c_prev = c_ff[s-1];
      end

      if (STEP == 0) begin : g_rz
         assign r_prev = '0;
      end else begin : g_rc
         assign r_prev = r_ff[s-1];
      end

      // STEP_BITS restoring division steps
      always_comb begin
         logic [DIM_BITS:0] r2;
         logic [DIM_BITS:0] diff;
         logic              ge;
         q_in = q_prev;
         r_in = r_prev;
         for (int b = 0; b < STEP_BITS; b++) begin
            r2   = {r_in, q_in[QW-1]};
            diff = r2 - {1'b0, od_eff[J]};
            ge   = r2 >= {1'b0, od_eff[J]};
            q_in = {q_in[QW-2:0], ge};
            r_in = ge ? diff[DIM_BITS-1:0] : r2[DIM_BITS-1:0];
         end
         c_in = c_prev;
         if (STEP == SPD - 1)
            c_in[J] = r_in;
      end

      always_ff @(posedge clock) begin
         if (reset)
            v_ff[s] <= 1'b0;
         else if (advance)
            v_ff[s] <= v_prev;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            q_ff[s] <= q_in;
            r_ff[s] <= r_in;
            c_ff[s] <= c_in;
         end
      end
   end

   // recombination stages: outermost dimension first
   for (genvar m = 0; m < MAX_RANK; m++) begin : g_mac
      logic [OFFSET_BITS-1:0]          acc_prev, acc_in;
      logic [OFFSET_BITS+DIM_BITS-1:0] prod;
      logic [DIM_BITS-1:0]             cz;

      if (m == 0) begin : g_first
         assign acc_prev = '0;
      end else begin : g_next
         assign acc_prev = acc_ff[m-1];
      end

      always_comb begin
         cz     = (sd_eff[m] == DIM_BITS'(1)) ? '0 : c_ff[ND+m-1][m];
         prod   = acc_prev * sd_eff[m];
         acc_in = prod[OFFSET_BITS-1:0] + OFFSET_BITS'(cz);
      end

      always_ff @(posedge clock) begin
         if (reset)
            v_ff[ND+m] <= 1'b0;
         else if (advance)
            v_ff[ND+m] <= v_ff[ND+m-1];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            acc_ff[m]   <= acc_in;
            c_ff[ND+m]  <= c_ff[ND+m-1];
         end
      end
   end

   // output
   assign rsp.valid      = v_ff[NS-1];
   assign rsp.bad_dims   = bad;
   assign rsp.src_offset = bad ? '0 : OUT_BITS'(acc_ff[MAX_RANK-1]);

endmodule

[rtl/bom_checker.sv]
// ----------------------------------------------------------------------------
// bom_checker
// Port-level checks of the broadcast offset mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "broadcast_offset_mapper_assert.svh"

module bom_checker import bom_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [OUT_BITS-1:0] rsp_src_offset,
   input logic                rsp_bad_dims
);

   // a pending result holds until taken
   `BOM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result item dropped")
   `BOM_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_src_offset), "stalled result changed")

   // input only backs up when the output is stalled
   `BOM_ASSERT(a_stall_src, !req_ready |-> rsp_valid && !rsp_ready, "input stalled without cause")

   // a bad shape always gives offset zero
   `BOM_ASSERT(a_bad_zero, rsp_valid && rsp_bad_dims |-> rsp_src_offset == '0, "bad dims with nonzero offset")

   // nothing comes out right after reset
   `BOM_ASSERT_ALWAYS(a_rst_empty, reset |=> !rsp_valid, "result item after reset")

endmodule

bind broadcast_offset_mapper bom_checker u_bom_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_src_offset (rsp.src_offset),
   .rsp_bad_dims   (rsp.bad_dims)
);
